// ===== design/gcb_pkg.sv =====
package gcb_pkg;

  localparam int AMOUNT_WIDTH_DEF = 24;

  // remainder after the largest note always stays below 50000
  localparam int REM_W = 16;
  localparam int QUO_W = 9;
  localparam int CNT_W = 2;
  localparam int LEFT_W = 6;

  // long division by the largest note retires two amount bits a stage
  localparam int DIV_BITS = 2;
  localparam int STEP_W = REM_W + DIV_BITS;
  localparam logic [STEP_W-1:0] TOP_X1 = STEP_W'(50000);
  localparam logic [STEP_W-1:0] TOP_X2 = STEP_W'(100000);
  localparam logic [STEP_W-1:0] TOP_X3 = STEP_W'(150000);

  // smaller denominations, index 0 is the largest
  localparam int NUM_SMALL = 9;
  localparam int COIN_STAGES = 3;
  localparam int COINS_PER_STAGE = NUM_SMALL / COIN_STAGES;
  localparam logic [NUM_SMALL-1:0][REM_W-1:0] SMALL_DENOM = {
    16'd50, 16'd100, 16'd200, 16'd500, 16'd1000,
    16'd2000, 16'd5000, 16'd10000, 16'd20000
  };

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [QUO_W-1:0] c_top;
    cnt_t [NUM_SMALL-1:0] c_small;
    logic [REM_W-1:0] rest;
  } coin_t;

endpackage

// ===== design/gcb_div_stage.sv =====
module gcb_div_stage import gcb_pkg::*; #(
  parameter int PW = AMOUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [PW-1:0]    up_amt,
  input  logic [REM_W-1:0] up_rem,
  input  logic [QUO_W-1:0] up_quo,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [PW-1:0]    dn_amt,
  output logic [REM_W-1:0] dn_rem,
  output logic [QUO_W-1:0] dn_quo
);

  logic                valid_r;
  logic [PW-1:0]       amt_r;
  logic [REM_W-1:0]    rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [REM_W-1:0]    rem_nxt;
  logic [DIV_BITS-1:0] digit;
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   diff1;
  logic [STEP_W-1:0]   diff2;
  logic [STEP_W-1:0]   diff3;

  // bring down the next two amount bits and take out up to three notes
  always_comb begin
    step  = {up_rem, up_amt[PW-1 -: DIV_BITS]};
    diff1 = step - TOP_X1;
    diff2 = step - TOP_X2;
    diff3 = step - TOP_X3;
    if (step >= TOP_X3) begin
      digit   = DIV_BITS'(3);
      rem_nxt = diff3[REM_W-1:0];
    end else if (step >= TOP_X2) begin
      digit   = DIV_BITS'(2);
      rem_nxt = diff2[REM_W-1:0];
    end else if (step >= TOP_X1) begin
      digit   = DIV_BITS'(1);
      rem_nxt = diff1[REM_W-1:0];
    end else begin
      digit   = '0;
      rem_nxt = step[REM_W-1:0];
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // quotient keeps only its low bits, which is all the count field carries
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      amt_r <= up_amt << DIV_BITS;
      rem_r <= rem_nxt;
      quo_r <= {up_quo[QUO_W-DIV_BITS-1:0], digit};
    end
  end

  assign dn_valid = valid_r;
  assign dn_amt   = amt_r;
  assign dn_rem   = rem_r;
  assign dn_quo   = quo_r;

endmodule

// ===== design/gcb_coin_stage.sv =====
module gcb_coin_stage import gcb_pkg::*; #(
  parameter int FIRST = 0,
  parameter int NUM   = COINS_PER_STAGE
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  coin_t up_word,
  output logic  dn_valid,
  input  logic  dn_ready,
  output coin_t dn_word
);

  logic  valid_r;
  coin_t word_r;
  coin_t word_nxt;

  // each denomination fits at most twice into what the larger one left
  always_comb begin
    logic [REM_W-1:0] d;
    logic [REM_W-1:0] d2;
    word_nxt = up_word;
    for (int i = 0; i < NUM; i++) begin
      d  = SMALL_DENOM[FIRST + i];
      d2 = d << 1;
      if (word_nxt.rest >= d2) begin
        word_nxt.c_small[FIRST + i] = CNT_W'(2);
        word_nxt.rest = word_nxt.rest - d2;
      end else if (word_nxt.rest >= d) begin
        word_nxt.c_small[FIRST + i] = CNT_W'(1);
        word_nxt.rest = word_nxt.rest - d;
      end else begin
        word_nxt.c_small[FIRST + i] = '0;
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== design/greedy_change_breakdown.sv =====
// greedy change breakdown: splits a cash amount over notes and coins from
// 50000 down to 50, largest first, and reports what no denomination can pay.
//
// input word : in_amount on in_valid / in_ready
// output word: one count per denomination, out_leftover (below 50) and
//              out_incomplete, on out_valid / out_ready
//
// a long division by 50000 takes two amount bits per stage, then three
// stages each settle three of the smaller denominations. a new amount is
// taken every cycle while in_ready is high; every stage holds one word and
// passes it on as soon as the next one is free, so bubbles close up.
// when out_ready is low the result holds on the outputs, the stages behind
// it keep filling and in_ready drops only once all of them are full.
// reset empties every stage; out_valid is low in the cycle after it.
// count_50000 carries the low 9 bits of its quotient for wide amounts.
module greedy_change_breakdown import gcb_pkg::*; #(
  parameter int AMOUNT_WIDTH = AMOUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [AMOUNT_WIDTH-1:0] in_amount,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [8:0]              out_count_50000,
  output logic [1:0]              out_count_20000,
  output logic                    out_count_10000,
  output logic                    out_count_5000,
  output logic [1:0]              out_count_2000,
  output logic                    out_count_1000,
  output logic                    out_count_500,
  output logic [1:0]              out_count_200,
  output logic                    out_count_100,
  output logic                    out_count_50,
  output logic [LEFT_W-1:0]       out_leftover,
  output logic                    out_incomplete
);

  localparam int NUM_DIV = (AMOUNT_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PW      = NUM_DIV * DIV_BITS;

  logic                div_valid [NUM_DIV+1];
  logic                div_ready [NUM_DIV+1];
  logic [PW-1:0]       div_amt   [NUM_DIV+1];
  logic [REM_W-1:0]    div_rem   [NUM_DIV+1];
  logic [QUO_W-1:0]    div_quo   [NUM_DIV+1];

  logic                coin_valid [COIN_STAGES+1];
  logic                coin_ready [COIN_STAGES+1];
  coin_t               coin_word  [COIN_STAGES+1];

  assign div_valid[0] = in_valid;
  assign in_ready     = div_ready[0];
  assign div_amt[0]   = PW'(in_amount);
  assign div_rem[0]   = '0;
  assign div_quo[0]   = '0;

  for (genvar s = 0; s < NUM_DIV; s++) begin : g_div
    gcb_div_stage #(
      .PW (PW)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (div_valid[s]),
      .up_ready (div_ready[s]),
      .up_amt   (div_amt[s]),
      .up_rem   (div_rem[s]),
      .up_quo   (div_quo[s]),
      .dn_valid (div_valid[s+1]),
      .dn_ready (div_ready[s+1]),
      .dn_amt   (div_amt[s+1]),
      .dn_rem   (div_rem[s+1]),
      .dn_quo   (div_quo[s+1])
    );
  end

  assign coin_valid[0]         = div_valid[NUM_DIV];
  assign div_ready[NUM_DIV]    = coin_ready[0];
  assign coin_word[0].c_top    = div_quo[NUM_DIV];
  assign coin_word[0].c_small  = '0;
  assign coin_word[0].rest     = div_rem[NUM_DIV];

  for (genvar s = 0; s < COIN_STAGES; s++) begin : g_coin
    gcb_coin_stage #(
      .FIRST (s * COINS_PER_STAGE),
      .NUM   (COINS_PER_STAGE)
    ) u_coin (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (coin_valid[s]),
      .up_ready (coin_ready[s]),
      .up_word  (coin_word[s]),
      .dn_valid (coin_valid[s+1]),
      .dn_ready (coin_ready[s+1]),
      .dn_word  (coin_word[s+1])
    );
  end

  assign out_valid                = coin_valid[COIN_STAGES];
  assign coin_ready[COIN_STAGES]  = out_ready;

  assign out_count_50000 = coin_word[COIN_STAGES].c_top;
  assign out_count_20000 = coin_word[COIN_STAGES].c_small[0];
  assign out_count_10000 = coin_word[COIN_STAGES].c_small[1][0];
  assign out_count_5000  = coin_word[COIN_STAGES].c_small[2][0];
  assign out_count_2000  = coin_word[COIN_STAGES].c_small[3];
  assign out_count_1000  = coin_word[COIN_STAGES].c_small[4][0];
  assign out_count_500   = coin_word[COIN_STAGES].c_small[5][0];
  assign out_count_200   = coin_word[COIN_STAGES].c_small[6];
  assign out_count_100   = coin_word[COIN_STAGES].c_small[7][0];
  assign out_count_50    = coin_word[COIN_STAGES].c_small[8][0];
  assign out_leftover    = coin_word[COIN_STAGES].rest[LEFT_W-1:0];
  assign out_incomplete  = |coin_word[COIN_STAGES].rest;

endmodule

// ===== design/gcb_checker.sv =====
module gcb_checker import gcb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [8:0]        out_count_50000,
  input logic [1:0]        out_count_20000,
  input logic [1:0]        out_count_2000,
  input logic [1:0]        out_count_200,
  input logic [LEFT_W-1:0] out_leftover,
  input logic              out_incomplete
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count_50000)
      && $stable(out_leftover) && $stable(out_incomplete))
    else $error("result word changed while stalled");

  a_leftover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_leftover < LEFT_W'(50) && out_incomplete == (out_leftover != '0))
    else $error("leftover out of range or flag mismatch");

  a_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count_20000 != 2'd3 && out_count_2000 != 2'd3
      && out_count_200 != 2'd3)
    else $error("denomination count too large");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word left over after reset");

endmodule

bind greedy_change_breakdown gcb_checker u_gcb_checker (.*);
